// ----- hw/rtl/session_slot_table_lru_macros.svh -----
// Assertion macros for the session slot table.
// Included by modules that carry concurrent checks; depends on nothing.
`ifndef SESSION_SLOT_TABLE_LRU_MACROS_SVH
`define SESSION_SLOT_TABLE_LRU_MACROS_SVH
// assert that a condition implies a consequence in the same cycle
`define SST_ASSERT_IMP(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("check failed");
// assert that a condition implies a consequence in the next cycle
`define SST_ASSERT_NXT(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("check failed");
`endif

// ----- hw/rtl/sst_pkg.sv -----
// Shared types and constants for the session slot table.
// Depends on nothing.
package sst_pkg;
  localparam int SLOTS_DEF        = 8;
  localparam int PAYLOAD_BITS_DEF = 32;
  localparam int STAMP_BITS_DEF   = 32;
  localparam int ID_BITS          = 31;
  localparam int SLOT_IDX_BITS    = 3;

  localparam logic MODE_SELECT = 1'b0;
  localparam logic MODE_FORGET = 1'b1;

  // per-cycle command broadcast to every cell
  typedef enum logic [2:0] {
    OP_NONE  = 3'b001,
    OP_WRITE = 3'b010,
    OP_CLEAR = 3'b100
  } cell_op_t;
endpackage

// ----- hw/rtl/sst_if.sv -----
// Valid/ready channel interface with a generic payload type.
// Depends on nothing.
interface sst_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/sst_cell.sv -----
// One slot of the table plus its stage of the scan chain.
// Depends on sst_pkg.
module sst_cell #(
  parameter int PAYLOAD_BITS = sst_pkg::PAYLOAD_BITS_DEF,
  parameter int STAMP_BITS   = sst_pkg::STAMP_BITS_DEF,
  parameter int IDX_BITS     = 3,
  parameter int MY_INDEX     = 0
) (
  input  logic                     clk,
  input  logic                     rst,
  // command from the controller
  input  sst_pkg::cell_op_t        op,
  input  logic [IDX_BITS-1:0]      op_idx,
  input  logic [sst_pkg::ID_BITS-1:0] wr_id,
  input  logic [STAMP_BITS-1:0]    wr_stamp,
  input  logic                     wr_stamp_en,
  input  logic                     wr_id_en,
  input  logic [PAYLOAD_BITS-1:0]  wr_pay,
  input  logic                     wr_pay_en,
  input  logic [sst_pkg::ID_BITS-1:0] key_a,
  input  logic [sst_pkg::ID_BITS-1:0] excl,
  // chain in: results of lower cells
  input  logic                     in_found_a,
  input  logic [IDX_BITS-1:0]      in_idx_a,
  input  logic [PAYLOAD_BITS-1:0]  in_pay_a,
  input  logic                     in_free,
  input  logic [IDX_BITS-1:0]      in_free_idx,
  input  logic                     in_lru,
  input  logic [IDX_BITS-1:0]      in_lru_idx,
  input  logic [STAMP_BITS-1:0]    in_lru_stamp,
  input  logic [STAMP_BITS-1:0]    in_top,
  output logic                     out_found_a,
  output logic [IDX_BITS-1:0]      out_idx_a,
  output logic [PAYLOAD_BITS-1:0]  out_pay_a,
  output logic                     out_free,
  output logic [IDX_BITS-1:0]      out_free_idx,
  output logic                     out_lru,
  output logic [IDX_BITS-1:0]      out_lru_idx,
  output logic [STAMP_BITS-1:0]    out_lru_stamp,
  output logic [STAMP_BITS-1:0]    out_top
);
  localparam logic [IDX_BITS-1:0] ME = IDX_BITS'(MY_INDEX);
  logic [sst_pkg::ID_BITS-1:0] id;
  logic [STAMP_BITS-1:0]       stamp;
  logic [PAYLOAD_BITS-1:0]     pay;
  logic occ, sel, match_a, lru_take;

  assign occ     = (id != '0);
  assign sel     = (op_idx == ME);
  assign match_a = occ && (id == key_a);
  assign lru_take = (id != excl) && (!in_lru || stamp < in_lru_stamp);

  always_comb begin
    out_found_a   = in_found_a || match_a;
    out_idx_a     = in_found_a ? in_idx_a : ME;
    out_pay_a     = in_found_a ? in_pay_a : pay;
    out_free      = in_free || !occ;
    out_free_idx  = in_free ? in_free_idx : ME;
    out_lru       = in_lru || lru_take;
    out_lru_idx   = lru_take ? ME : in_lru_idx;
    out_lru_stamp = lru_take ? stamp : in_lru_stamp;
    out_top       = (occ && stamp > in_top) ? stamp : in_top;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      id    <= '0;
      stamp <= '0;
      pay   <= '0;
    end else if (sel) begin
      case (op)
        sst_pkg::OP_WRITE: begin
          if (wr_id_en)    id    <= wr_id;
          if (wr_stamp_en) stamp <= wr_stamp;
          if (wr_pay_en)   pay   <= wr_pay;
        end
        sst_pkg::OP_CLEAR: begin
          id    <= '0;
          stamp <= '0;
          pay   <= '0;
        end
        default: ;
      endcase
    end
  end
endmodule

// ----- hw/rtl/session_slot_table_lru.sv -----
// Session slot table with LRU replacement (top level).
// Channels: in (mode, req_id, active_payload), out (result_payload,
// active_id_out, hit, slot_index, evicted), valid/ready words via sst_if.
// One result word per input word. After the input word is taken, an item
// passes through the sequencer states in order: save (scan the chain of slot
// cells for the old active id and write the saved payload, or for a forget
// find and clear the requested slot), lookup (scan for the new id and restore
// or allocate), finish (latch the result fields) and output (load the output
// register once it is empty or being drained). The next word is taken only
// after the last one has left the output state.
// The input is taken only in the idle state and only while the output
// register is empty or being drained in that same cycle, so a stalled
// receiver holds the result and blocks the next word; nothing is dropped.
// Reset (synchronous, rst high) frees all slots at once and clears the
// active session.
// Depends on sst_pkg, sst_if, sst_cell and the macros header.
`include "session_slot_table_lru_macros.svh"
module session_slot_table_lru #(
  parameter int SLOTS        = sst_pkg::SLOTS_DEF,
  parameter int PAYLOAD_BITS = sst_pkg::PAYLOAD_BITS_DEF,
  parameter int STAMP_BITS   = sst_pkg::STAMP_BITS_DEF
) (
  input logic clk,
  input logic rst,
  sst_if.sink   in,
  sst_if.source out
);
  localparam int IDX_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int IB = sst_pkg::ID_BITS;
  localparam logic [STAMP_BITS-1:0] STAMP_MAX = '1;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SAVE  = 5'b00010,
    S_LOOK  = 5'b00100,
    S_FIN   = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t state;
  logic mode_r;
  logic [IB-1:0] id_r, active_id;
  logic [PAYLOAD_BITS-1:0] pay_r;
  logic ev_r;

  sst_pkg::cell_op_t op;
  logic [IDX_BITS-1:0] op_idx;
  logic [IB-1:0] wr_id, key_a;
  logic [STAMP_BITS-1:0] wr_stamp;
  logic [PAYLOAD_BITS-1:0] wr_pay;
  logic wr_id_en, wr_stamp_en, wr_pay_en;

  logic                    c_found [SLOTS+1];
  logic [IDX_BITS-1:0]     c_idx   [SLOTS+1];
  logic [PAYLOAD_BITS-1:0] c_pay   [SLOTS+1];
  logic                    c_free  [SLOTS+1];
  logic [IDX_BITS-1:0]     c_fidx  [SLOTS+1];
  logic                    c_lru   [SLOTS+1];
  logic [IDX_BITS-1:0]     c_lidx  [SLOTS+1];
  logic [STAMP_BITS-1:0]   c_lst   [SLOTS+1];
  logic [STAMP_BITS-1:0]   c_top   [SLOTS+1];

  assign c_found[0] = 1'b0; assign c_idx[0] = '0; assign c_pay[0] = '0;
  assign c_free[0] = 1'b0;  assign c_fidx[0] = '0;
  assign c_lru[0] = 1'b0;   assign c_lidx[0] = '0; assign c_lst[0] = '0;
  assign c_top[0] = '0;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    sst_cell #(.PAYLOAD_BITS(PAYLOAD_BITS), .STAMP_BITS(STAMP_BITS),
               .IDX_BITS(IDX_BITS), .MY_INDEX(g)) u_cell (
      .clk, .rst, .op, .op_idx, .wr_id, .wr_stamp, .wr_stamp_en, .wr_id_en,
      .wr_pay, .wr_pay_en, .key_a, .excl(active_id),
      .in_found_a(c_found[g]), .in_idx_a(c_idx[g]), .in_pay_a(c_pay[g]),
      .in_free(c_free[g]), .in_free_idx(c_fidx[g]),
      .in_lru(c_lru[g]), .in_lru_idx(c_lidx[g]), .in_lru_stamp(c_lst[g]),
      .in_top(c_top[g]),
      .out_found_a(c_found[g+1]), .out_idx_a(c_idx[g+1]), .out_pay_a(c_pay[g+1]),
      .out_free(c_free[g+1]), .out_free_idx(c_fidx[g+1]),
      .out_lru(c_lru[g+1]), .out_lru_idx(c_lidx[g+1]), .out_lru_stamp(c_lst[g+1]),
      .out_top(c_top[g+1]));
  end

  logic found;
  logic [IDX_BITS-1:0] fidx, alloc_idx;
  logic alloc_ev;
  logic [STAMP_BITS-1:0] fresh;
  assign found = c_found[SLOTS];
  assign fidx  = c_idx[SLOTS];
  assign alloc_idx = c_free[SLOTS] ? c_fidx[SLOTS] :
                     (c_lru[SLOTS] ? c_lidx[SLOTS] : '0);
  assign alloc_ev  = !c_free[SLOTS];
  assign fresh = (c_top[SLOTS] == STAMP_MAX) ? STAMP_MAX : c_top[SLOTS] + 1'b1;

  // result register
  logic [PAYLOAD_BITS-1:0] res_pay;
  logic [IB-1:0] res_id;
  logic res_hit, res_ev;
  logic [IDX_BITS-1:0] res_slot;
  logic out_valid;

  // take the input only when idle and the output register is free or draining
  assign in.ready  = (state == S_IDLE) && (!out_valid || out.ready);
  assign out.valid = out_valid;
  assign out.data.result_payload = 32'(res_pay);
  assign out.data.active_id_out  = res_id;
  assign out.data.hit            = res_hit;
  assign out.data.slot_index     = 3'(res_slot);
  assign out.data.evicted        = res_ev;

  always_comb begin
    op = sst_pkg::OP_NONE; op_idx = '0;
    wr_id = id_r; wr_stamp = fresh; wr_pay = '0;
    wr_id_en = 1'b0; wr_stamp_en = 1'b0; wr_pay_en = 1'b0;
    key_a = id_r;
    case (state)
      S_SAVE: begin
        if (mode_r == sst_pkg::MODE_SELECT) key_a = active_id;
        if (mode_r == sst_pkg::MODE_FORGET) begin
          if (id_r != '0 && found) begin
            op = sst_pkg::OP_CLEAR; op_idx = fidx;
          end
        end else if (id_r != '0 && id_r != active_id && active_id != '0) begin
          op = sst_pkg::OP_WRITE; wr_pay = pay_r; wr_pay_en = 1'b1;
          if (found) op_idx = fidx;
          else begin
            op_idx = alloc_idx; wr_id = active_id;
            wr_id_en = 1'b1; wr_stamp_en = 1'b1;
          end
        end
      end
      S_LOOK: begin
        if (mode_r == sst_pkg::MODE_SELECT && id_r != '0 && id_r != active_id) begin
          op = sst_pkg::OP_WRITE; wr_stamp_en = 1'b1;
          if (found) op_idx = fidx;
          else begin
            op_idx = alloc_idx; wr_id_en = 1'b1; wr_pay_en = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; active_id <= '0; out_valid <= 1'b0;
    end else begin
      if (out.valid && out.ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (in.valid && in.ready) begin
          mode_r <= in.data.mode; id_r <= in.data.req_id;
          pay_r  <= PAYLOAD_BITS'(in.data.active_payload);
          ev_r   <= 1'b0; state <= S_SAVE;
        end
        S_SAVE: begin
          res_pay <= pay_r; res_hit <= 1'b0; res_slot <= '0;
          if (mode_r == sst_pkg::MODE_FORGET) begin
            if (id_r != '0) begin
              res_hit <= found; res_slot <= found ? fidx : '0;
              if (active_id == id_r) begin
                res_pay <= '0; active_id <= '0;
              end
            end
          end else if (id_r == '0) begin
            res_pay <= '0; active_id <= '0;
          end else if (id_r != active_id && active_id != '0 && !found)
            ev_r <= alloc_ev;
          state <= S_LOOK;
        end
        S_LOOK: begin
          if (mode_r == sst_pkg::MODE_SELECT && id_r != '0) begin
            res_hit <= found; res_slot <= found ? fidx : '0;
            if (id_r != active_id) begin
              if (found) res_pay <= c_pay[SLOTS];
              else begin
                res_pay <= '0; res_slot <= alloc_idx;
                if (alloc_ev) ev_r <= 1'b1;
              end
              active_id <= id_r;
            end
          end
          state <= S_FIN;
        end
        S_FIN: begin
          res_id <= active_id; res_ev <= ev_r; state <= S_OUT;
        end
        S_OUT: if (!out_valid || out.ready) begin
          out_valid <= 1'b1; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `SST_ASSERT_NXT(a_take_starts, clk, rst, in.valid && in.ready, state == S_SAVE)
  `SST_ASSERT_IMP(a_busy_not_ready, clk, rst, state != S_IDLE, !in.ready)
  `SST_ASSERT_NXT(a_hold_stall, clk, rst, out.valid && !out.ready, out.valid)
  `SST_ASSERT_IMP(a_forget_no_ev, clk, rst,
                  out.valid && mode_r == sst_pkg::MODE_FORGET, !out.data.evicted)
endmodule

// ----- test/tb_sst_types_pkg.sv -----
// Word formats for the session slot table channels, used by the testbench.
// Depends on sst_pkg for the id and slot index widths.
`timescale 1ns / 1ps
package tb_sst_types_pkg;
  typedef struct packed {
    logic                         mode;
    logic [sst_pkg::ID_BITS-1:0]  req_id;
    logic [31:0]                  active_payload;
  } sel_req_t;

  typedef struct packed {
    logic [31:0]                       result_payload;
    logic [sst_pkg::ID_BITS-1:0]       active_id_out;
    logic                              hit;
    logic [sst_pkg::SLOT_IDX_BITS-1:0] slot_index;
    logic                              evicted;
  } sel_rsp_t;
endpackage

// ----- test/sst_checker.sv -----
// Watches both channels of the session slot table, predicts each result word
// from its own copy of the table and compares. Depends on sst_pkg, tb_sst_types_pkg.
`timescale 1ns / 1ps
module sst_checker
  import sst_pkg::*;
  import tb_sst_types_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     in_ready,
  input  sel_req_t in_data,
  input  logic     out_valid,
  input  logic     out_ready,
  input  sel_rsp_t out_data,
  output int       fails,
  output int       pending,
  output int       n_checked,
  output int       n_hits,
  output int       n_evicted
);
  localparam int NSLOT = SLOTS_DEF;

  logic [ID_BITS-1:0] tbl_id [NSLOT];
  logic [31:0]        tbl_stamp [NSLOT];
  logic [31:0]        tbl_pay [NSLOT];
  logic [ID_BITS-1:0] cur_id;
  sel_rsp_t           expected_rsp [$];

  function automatic int find_id(logic [ID_BITS-1:0] id);
    if (id == '0) return -1;
    for (int i = 0; i < NSLOT; i++) if (tbl_id[i] == id) return i;
    return -1;
  endfunction

  function automatic logic [31:0] next_stamp();
    logic [31:0] top;
    top = 0;
    for (int i = 0; i < NSLOT; i++)
      if (tbl_id[i] != '0 && tbl_stamp[i] > top) top = tbl_stamp[i];
    return (top == 32'hFFFF_FFFF) ? top : top + 32'd1;
  endfunction

  // first free slot, else least stamp not excluded, else slot 0
  function automatic int alloc_slot(logic [ID_BITS-1:0] excl, logic [ID_BITS-1:0] id,
                                    ref logic ev);
    logic [31:0] st;
    int pick;
    st = next_stamp();
    pick = -1;
    for (int i = 0; i < NSLOT; i++)
      if (pick < 0 && tbl_id[i] == '0) pick = i;
    if (pick < 0) begin
      for (int i = 0; i < NSLOT; i++) begin
        if (tbl_id[i] == excl) continue;
        if (pick < 0 || tbl_stamp[i] < tbl_stamp[pick]) pick = i;
      end
      if (pick < 0) pick = 0;
      ev = 1'b1;
    end
    tbl_id[pick] = id;
    tbl_stamp[pick] = st;
    tbl_pay[pick] = '0;
    return pick;
  endfunction

  function automatic sel_rsp_t switch_session(sel_req_t w);
    sel_rsp_t r;
    logic [31:0] res;
    logic hit, ev;
    int slot, s;
    res = w.active_payload;
    hit = 0;
    ev = 0;
    slot = -1;
    if (w.mode == MODE_FORGET) begin
      if (w.req_id != '0) begin
        if (cur_id == w.req_id) begin
          res = '0;
          cur_id = '0;
        end
        slot = find_id(w.req_id);
        if (slot >= 0) begin
          hit = 1;
          tbl_id[slot] = '0;
          tbl_stamp[slot] = '0;
          tbl_pay[slot] = '0;
        end
      end
    end else if (w.req_id == '0) begin
      res = '0;
      cur_id = '0;
    end else if (w.req_id == cur_id) begin
      slot = find_id(w.req_id);
      hit = slot >= 0;
    end else begin
      // save the outgoing payload, then restore or allocate
      if (cur_id != '0) begin
        s = find_id(cur_id);
        if (s < 0) s = alloc_slot(cur_id, cur_id, ev);
        tbl_pay[s] = w.active_payload;
      end
      slot = find_id(w.req_id);
      if (slot >= 0) begin
        hit = 1;
        res = tbl_pay[slot];
        tbl_stamp[slot] = next_stamp();
      end else begin
        res = '0;
        slot = alloc_slot(cur_id, w.req_id, ev);
      end
      cur_id = w.req_id;
    end
    r.result_payload = res;
    r.active_id_out  = cur_id;
    r.hit            = hit;
    r.slot_index     = (slot >= 0) ? slot[SLOT_IDX_BITS-1:0] : '0;
    r.evicted        = ev;
    return r;
  endfunction

  task automatic report(string what, logic [31:0] exp_v, logic [31:0] got_v);
    $display("[%0t] %s: expected %h, got %h", $time, what, exp_v, got_v);
    fails++;
  endtask

  assign pending = expected_rsp.size();

  initial begin
    fails = 0;
    n_checked = 0;
    n_hits = 0;
    n_evicted = 0;
  end

  always @(posedge clk) begin
    sel_rsp_t e;
    if (rst) begin
      for (int i = 0; i < NSLOT; i++) begin
        tbl_id[i] = '0;
        tbl_stamp[i] = '0;
        tbl_pay[i] = '0;
      end
      cur_id = '0;
      expected_rsp.delete();
    end else begin
      if (in_valid && in_ready) expected_rsp.push_back(switch_session(in_data));
      if (out_valid && out_ready) begin
        if (expected_rsp.size() == 0) begin
          report("unexpected result word", 0, out_data.result_payload);
        end else begin
          e = expected_rsp.pop_front();
          n_checked++;
          if (e.hit) n_hits++;
          if (e.evicted) n_evicted++;
          if (out_data.result_payload != e.result_payload)
            report("result_payload", e.result_payload, out_data.result_payload);
          if (out_data.active_id_out != e.active_id_out)
            report("active_id_out", e.active_id_out, out_data.active_id_out);
          if (out_data.hit != e.hit) report("hit", e.hit, out_data.hit);
          if (out_data.slot_index != e.slot_index)
            report("slot_index", e.slot_index, out_data.slot_index);
          if (out_data.evicted != e.evicted) report("evicted", e.evicted, out_data.evicted);
        end
      end
    end
  end
endmodule

// ----- test/tb_session_slot_table_lru.sv -----
// Testbench top for session_slot_table_lru: drives select/forget words with
// random gaps and output stalls; sst_checker does the prediction and checks.
`timescale 1ns / 1ps
module tb_session_slot_table_lru;
  import sst_pkg::*;
  import tb_sst_types_pkg::*;

  localparam int RANDOM_WORDS = 1400;
  localparam int CALM_FROM    = 1200;
  localparam int CYCLE_LIMIT  = 400000;

  logic clk = 0;
  logic rst = 1;
  logic idle_on = 1;
  int   cycles = 0;
  int   fails, pending, n_checked, n_hits, n_evicted;
  int   stall_left = 0;
  int   n_sent = 0;

  sst_if #(.payload_t(sel_req_t)) req_ch ();
  sst_if #(.payload_t(sel_rsp_t)) rsp_ch ();

  session_slot_table_lru dut (.clk(clk), .rst(rst), .in(req_ch), .out(rsp_ch));

  sst_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(req_ch.valid), .in_ready(req_ch.ready), .in_data(req_ch.data),
    .out_valid(rsp_ch.valid), .out_ready(rsp_ch.ready), .out_data(rsp_ch.data),
    .fails(fails), .pending(pending), .n_checked(n_checked),
    .n_hits(n_hits), .n_evicted(n_evicted)
  );

  always #5 clk = ~clk;

  initial begin
    req_ch.valid = 0;
    req_ch.data = '0;
    rsp_ch.ready = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("session_slot_table_lru: mismatch");
      $finish;
    end
  end

  // receiver stalls in bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      rsp_ch.ready <= 0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 15);
      rsp_ch.ready <= 0;
    end else begin
      rsp_ch.ready <= 1;
    end
  end

  task automatic send_word(logic mode, logic [ID_BITS-1:0] id, logic [31:0] pay);
    sel_req_t w;
    w.mode = mode;
    w.req_id = id;
    w.active_payload = pay;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      req_ch.valid <= 0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    req_ch.valid <= 1;
    req_ch.data <= w;
    do @(posedge clk); while (!req_ch.ready);
    n_sent++;
  endtask

  function automatic logic [ID_BITS-1:0] pick_id();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 80) return ID_BITS'($urandom_range(1, 11));
    if (r < 85) return {ID_BITS{1'b1}};
    return ID_BITS'($urandom);
  endfunction

  function automatic logic [31:0] pick_pay();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  initial begin
    int waited;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: none cases, same-id reselect, fill and evict, forget paths
    send_word(MODE_SELECT, '0, 32'hFFFF_FFFF);
    send_word(MODE_FORGET, '0, 32'h1234_5678);
    send_word(MODE_SELECT, ID_BITS'(1), 32'hFFFF_FFFF);
    send_word(MODE_SELECT, ID_BITS'(1), 32'hA5A5_A5A5);
    for (int i = 2; i <= 10; i++) send_word(MODE_SELECT, ID_BITS'(i), 32'(32'h100 + i));
    send_word(MODE_SELECT, {ID_BITS{1'b1}}, 32'h0);
    send_word(MODE_SELECT, ID_BITS'(3), 32'hFFFF_FFFF);
    send_word(MODE_FORGET, ID_BITS'(3), 32'h5555_5555);
    send_word(MODE_FORGET, ID_BITS'(10), 32'h0);
    send_word(MODE_FORGET, ID_BITS'(12345), 32'hDEAD_BEEF);
    send_word(MODE_SELECT, '0, 32'h1);
    send_word(MODE_SELECT, {ID_BITS{1'b1}}, 32'h7);
    send_word(MODE_FORGET, {ID_BITS{1'b1}}, 32'h8);

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == CALM_FROM) idle_on = 0;
      if (n == RANDOM_WORDS / 2) begin
        // hold off until the pipeline has drained
        req_ch.valid <= 0;
        do @(posedge clk); while (pending != 0);
      end
      send_word(($urandom_range(0, 4) == 0) ? MODE_FORGET : MODE_SELECT,
                pick_id(), pick_pay());
    end
    req_ch.valid <= 0;

    waited = 0;
    while (pending != 0 && waited < 10000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);

    $display("covered %0d words, %0d results checked, %0d hits, %0d evictions",
             n_sent, n_checked, n_hits, n_evicted);
    if (fails == 0 && pending == 0) begin
      $display("session_slot_table_lru: match");
    end else begin
      $display("session_slot_table_lru: mismatch");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/sst_pkg.sv
hw/rtl/sst_if.sv
hw/rtl/sst_cell.sv
hw/rtl/session_slot_table_lru.sv
test/tb_sst_types_pkg.sv
test/sst_checker.sv
test/tb_session_slot_table_lru.sv
